/* sv/indexed_min_heap_timer_assert.svh */
// Assertion macros for the indexed min-heap timer.
// Used by the top level; expects clk_i and rst_ni in the scope of the caller.
`ifndef INDEXED_MIN_HEAP_TIMER_ASSERT_SVH
`define INDEXED_MIN_HEAP_TIMER_ASSERT_SVH
`ifndef SYNTHESIS
`define IMHT_ASSERT_IMP(lbl, a, b) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |-> (b)) \
    else $error("assertion failed");
`define IMHT_ASSERT_NXT(lbl, a, b) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |=> (b)) \
    else $error("assertion failed");
`else
`define IMHT_ASSERT_IMP(lbl, a, b)
`define IMHT_ASSERT_NXT(lbl, a, b)
`endif
`endif

/* sv/imht_pkg.sv */
// Shared types, codes and helper functions of the indexed min-heap timer.
// No dependencies.
package imht_pkg;

  localparam logic [2:0] CMD_ADD   = 3'd0;
  localparam logic [2:0] CMD_ADJ   = 3'd1;
  localparam logic [2:0] CMD_DEL   = 3'd2;
  localparam logic [2:0] CMD_TICK  = 3'd3;
  localparam logic [2:0] CMD_CLEAR = 3'd4;

  localparam int unsigned MAX_RES = 64;
  localparam int unsigned RCW     = 7;
  localparam int unsigned EBW     = 6;

  localparam logic [31:0] WAIT_MAX   = 32'd4194303;
  localparam logic [22:0] WAIT_EMPTY = 23'h7FFFFF;
  localparam logic [31:0] SIGN_FLIP  = 32'h8000_0000;

  typedef enum logic [2:0] {
    OP_ADD, OP_ADJ, OP_DEL, OP_TICK, OP_CLEAR, OP_NOP
  } op_e;

  typedef enum logic [1:0] {
    KIND_DONE, KIND_EXP, KIND_FULL, KIND_ABS
  } kind_e;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_MAP, S_OWN, S_LAST, S_DN_RD, S_DN_CMP, S_UP_RD,
    S_UP_CMP, S_PUT, S_TOP, S_TCMP, S_WAIT, S_WCALC, S_EMIT
  } state_e;

  typedef struct packed {
    op_e         op;
    logic        id_ok;
    logic [15:0] id;
    logic [21:0] tmo;
  } cmd_t;

  typedef struct packed {
    kind_e              kind;
    logic [15:0]        id;
    logic signed [22:0] wait_ms;
    logic               last;
  } res_t;

  typedef struct packed {
    logic [31:0] dl;
    logic [15:0] own;
  } hent_t;

  // deadlines compare as signed distances from now
  function automatic logic earlier(logic [31:0] a, logic [31:0] b, logic [31:0] now);
    logic [31:0] ka;
    logic [31:0] kb;
    ka = (a - now) ^ SIGN_FLIP;
    kb = (b - now) ^ SIGN_FLIP;
    return ka < kb;
  endfunction

  function automatic logic [22:0] wait_of(logic [31:0] dl, logic [31:0] now,
                                          logic nonempty);
    logic [31:0] d;
    d = dl - now;
    if (!nonempty) return WAIT_EMPTY;
    if (d[31]) return 23'd0;
    if (d > WAIT_MAX) return WAIT_MAX[22:0];
    return d[22:0];
  endfunction

endpackage

/* sv/imht_front.sv */
// Command front end: classifies incoming commands and holds them in a
// two-entry queue for the engine. Depends on imht_pkg.
module imht_front #(
  parameter int unsigned ID_COUNT = 65536
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  output logic                full_o,
  input  logic                busy_i,
  input  logic [2:0]          cmd_i,
  input  logic [15:0]         conn_id_i,
  input  logic [21:0]         timeout_ms_i,
  output logic                valid_o,
  input  logic                pop_i,
  output imht_pkg::cmd_t      cmd_o
);

  imht_pkg::cmd_t ent_q [2];
  imht_pkg::cmd_t ent_d;
  logic           wp_q, rp_q;
  logic [1:0]     cnt_q;
  logic           wr, rd;

  always_comb begin
    ent_d.id    = conn_id_i;
    ent_d.tmo   = timeout_ms_i;
    ent_d.id_ok = ({1'b0, conn_id_i} < 17'(ID_COUNT));
    case (cmd_i)
      imht_pkg::CMD_ADD:   ent_d.op = imht_pkg::OP_ADD;
      imht_pkg::CMD_ADJ:   ent_d.op = imht_pkg::OP_ADJ;
      imht_pkg::CMD_DEL:   ent_d.op = imht_pkg::OP_DEL;
      imht_pkg::CMD_TICK:  ent_d.op = imht_pkg::OP_TICK;
      imht_pkg::CMD_CLEAR: ent_d.op = imht_pkg::OP_CLEAR;
      default:             ent_d.op = imht_pkg::OP_NOP;
    endcase
  end

  assign full_o  = (cnt_q == 2'd2) || busy_i;
  assign valid_o = (cnt_q != 2'd0);
  assign wr      = push_i && !full_o;
  assign rd      = pop_i && valid_o;
  assign cmd_o   = ent_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (wr) wp_q <= ~wp_q;
      if (rd) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) ent_q[wp_q] <= ent_d;
  end

endmodule

/* sv/imht_rfifo.sv */
// Result queue between the engine and the result port, two entries deep.
// Depends on imht_pkg.
module imht_rfifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  imht_pkg::res_t res_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output imht_pkg::res_t res_o
);

  imht_pkg::res_t ent_q [2];
  logic           wp_q, rp_q;
  logic [1:0]     cnt_q;
  logic           wr, rd;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign wr      = push_i && !full_o;
  assign rd      = pop_i && !empty_o;
  assign res_o   = ent_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (wr) wp_q <= ~wp_q;
      if (rd) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) ent_q[wp_q] <= res_i;
  end

endmodule

/* sv/imht_engine.sv */
// Heap engine: id map lookup, sift up/down over the slot memory, tick expiry
// and result emission. Depends on imht_pkg.
module imht_engine #(
  parameter int unsigned CAPACITY = 64,
  parameter int unsigned ID_COUNT = 65536
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  output logic           busy_o,
  input  logic           cmd_valid_i,
  output logic           cmd_pop_o,
  input  imht_pkg::cmd_t cmd_i,
  output logic           res_push_o,
  input  logic           res_full_i,
  output imht_pkg::res_t res_o
);

  localparam int unsigned SW = $clog2(CAPACITY);
  localparam int unsigned NW = $clog2(CAPACITY + 1);
  localparam int unsigned CW = SW + 2;
  localparam int unsigned IW = $clog2(ID_COUNT);

  // memories
  imht_pkg::hent_t heap_mem [CAPACITY];
  logic [SW-1:0]   map_mem  [ID_COUNT];
  logic [15:0]     exp_mem  [imht_pkg::MAX_RES];

  logic            h_re_a, h_re_b, h_we;
  logic [SW-1:0]   h_ra, h_rb, h_wa;
  imht_pkg::hent_t h_wd, h_rda, h_rdb;
  logic            m_re, m_we;
  logic [IW-1:0]   m_ra, m_wa;
  logic [SW-1:0]   m_wd, m_rd;
  logic            e_re, e_we;
  logic [imht_pkg::EBW-1:0] e_ra, e_wa;
  logic [15:0]     e_wd, e_rd;

  always_ff @(posedge clk_i) begin
    if (h_we) heap_mem[h_wa] <= h_wd;
    if (h_re_a) h_rda <= heap_mem[h_ra];
    if (h_re_b) h_rdb <= heap_mem[h_rb];
  end

  always_ff @(posedge clk_i) begin
    if (m_we) map_mem[m_wa] <= m_wd;
    if (m_re) m_rd <= map_mem[m_ra];
  end

  always_ff @(posedge clk_i) begin
    if (e_we) exp_mem[e_wa] <= e_wd;
    if (e_re) e_rd <= exp_mem[e_ra];
  end

  imht_pkg::state_e state_q, state_d;
  logic [NW-1:0]    size_q, size_d;
  logic [31:0]      now_q, now_d;
  imht_pkg::op_e    op_q, op_d;
  logic [15:0]      id_q, id_d;
  logic [21:0]      tmo_q, tmo_d;
  logic             inr_q, inr_d;
  logic [SW-1:0]    s_q, s_d;
  logic [SW-1:0]    hole_q, hole_d;
  logic [CW-1:0]    c_q, c_d;
  logic             rv_q, rv_d;
  logic             moved_q, moved_d;
  imht_pkg::hent_t  cur_q, cur_d;
  imht_pkg::kind_e  kind_q, kind_d;
  logic [imht_pkg::RCW-1:0] cnt_q, cnt_d, emit_q, emit_d;
  logic [22:0]      wait_q, wait_d;
  logic [IW-1:0]    init_q, init_d;

  logic [CW-1:0]    n_ext, c_new, hole_ext;
  logic [SW-1:0]    parent;
  logic [NW-1:0]    size_m1;
  imht_pkg::hent_t  child;
  logic [SW-1:0]    child_idx;
  logic [31:0]      dtop;
  logic [imht_pkg::RCW-1:0] n_res, emit_p1;
  logic             present;

  always_comb begin
    n_ext     = CW'(size_q);
    hole_ext  = CW'(hole_q);
    c_new     = (hole_ext << 1) + CW'(1);
    parent    = SW'((hole_q - SW'(1)) >> 1);
    size_m1   = size_q - NW'(1);
    dtop      = h_rda.dl - now_q;
    present   = inr_q && (h_rda.own == id_q);
    if (rv_q && imht_pkg::earlier(h_rdb.dl, h_rda.dl, now_q)) begin
      child     = h_rdb;
      child_idx = SW'(c_q + CW'(1));
    end else begin
      child     = h_rda;
      child_idx = c_q[SW-1:0];
    end
    n_res   = ((op_q == imht_pkg::OP_TICK) && (cnt_q != '0)) ? cnt_q : imht_pkg::RCW'(1);
    emit_p1 = emit_q + imht_pkg::RCW'(1);
  end

  always_comb begin
    state_d = state_q;
    size_d  = size_q;
    now_d   = now_q;
    op_d    = op_q;
    id_d    = id_q;
    tmo_d   = tmo_q;
    inr_d   = inr_q;
    s_d     = s_q;
    hole_d  = hole_q;
    c_d     = c_q;
    rv_d    = rv_q;
    moved_d = moved_q;
    cur_d   = cur_q;
    kind_d  = kind_q;
    cnt_d   = cnt_q;
    emit_d  = emit_q;
    wait_d  = wait_q;
    init_d  = init_q;

    h_re_a = 1'b0; h_ra = '0;
    h_re_b = 1'b0; h_rb = '0;
    h_we   = 1'b0; h_wa = hole_q; h_wd = cur_q;
    m_re   = 1'b0; m_ra = cmd_i.id[IW-1:0];
    m_we   = 1'b0; m_wa = cur_q.own[IW-1:0]; m_wd = hole_q;
    e_re   = 1'b0; e_ra = '0;
    e_we   = 1'b0; e_wa = cnt_q[imht_pkg::EBW-1:0]; e_wd = h_rda.own;

    cmd_pop_o  = 1'b0;
    res_push_o = 1'b0;
    res_o.kind    = kind_q;
    res_o.id      = 16'd0;
    res_o.wait_ms = wait_q;
    res_o.last    = (emit_p1 == n_res);

    case (state_q)
      imht_pkg::S_INIT: begin
        m_we = 1'b1;
        m_wa = init_q;
        m_wd = '0;
        init_d = init_q + IW'(1);
        if (init_q == IW'(ID_COUNT - 1)) state_d = imht_pkg::S_IDLE;
      end
      imht_pkg::S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          op_d   = cmd_i.op;
          id_d   = cmd_i.id;
          tmo_d  = cmd_i.tmo;
          kind_d = imht_pkg::KIND_DONE;
          case (cmd_i.op)
            imht_pkg::OP_ADD, imht_pkg::OP_ADJ, imht_pkg::OP_DEL: begin
              if (!cmd_i.id_ok) begin
                kind_d  = imht_pkg::KIND_ABS;
                state_d = imht_pkg::S_WAIT;
              end else begin
                m_re    = 1'b1;
                state_d = imht_pkg::S_MAP;
              end
            end
            imht_pkg::OP_TICK: begin
              now_d   = now_q + 32'd1;
              cnt_d   = '0;
              state_d = imht_pkg::S_TOP;
            end
            imht_pkg::OP_CLEAR: begin
              size_d  = '0;
              state_d = imht_pkg::S_WAIT;
            end
            default: state_d = imht_pkg::S_WAIT;
          endcase
        end
      end
      imht_pkg::S_MAP: begin
        // a map entry counts only if its slot is live and owned by this id
        s_d     = m_rd;
        inr_d   = (NW'(m_rd) < size_q);
        h_re_a  = 1'b1;
        h_ra    = m_rd;
        state_d = imht_pkg::S_OWN;
      end
      imht_pkg::S_OWN: begin
        cur_d.dl  = now_q + {10'd0, tmo_q};
        cur_d.own = id_q;
        moved_d   = 1'b0;
        if (present) begin
          hole_d = s_q;
          if (op_q == imht_pkg::OP_DEL) begin
            size_d = size_m1;
            if (NW'(s_q) < size_m1) begin
              h_re_a  = 1'b1;
              h_ra    = size_m1[SW-1:0];
              state_d = imht_pkg::S_LAST;
            end else begin
              state_d = imht_pkg::S_WAIT;
            end
          end else begin
            state_d = imht_pkg::S_DN_RD;
          end
        end else if (op_q == imht_pkg::OP_ADD) begin
          if (size_q >= NW'(CAPACITY)) begin
            kind_d  = imht_pkg::KIND_FULL;
            state_d = imht_pkg::S_WAIT;
          end else begin
            hole_d  = size_q[SW-1:0];
            size_d  = size_q + NW'(1);
            state_d = imht_pkg::S_UP_RD;
          end
        end else begin
          kind_d  = imht_pkg::KIND_ABS;
          state_d = imht_pkg::S_WAIT;
        end
      end
      imht_pkg::S_LAST: begin
        cur_d   = h_rda;
        moved_d = 1'b0;
        state_d = imht_pkg::S_DN_RD;
      end
      imht_pkg::S_DN_RD: begin
        if (c_new < n_ext) begin
          h_re_a  = 1'b1;
          h_ra    = c_new[SW-1:0];
          rv_d    = (c_new + CW'(1)) < n_ext;
          h_re_b  = rv_d;
          h_rb    = SW'(c_new + CW'(1));
          c_d     = c_new;
          state_d = imht_pkg::S_DN_CMP;
        end else begin
          state_d = moved_q ? imht_pkg::S_PUT : imht_pkg::S_UP_RD;
        end
      end
      imht_pkg::S_DN_CMP: begin
        if (imht_pkg::earlier(cur_q.dl, child.dl, now_q)) begin
          state_d = moved_q ? imht_pkg::S_PUT : imht_pkg::S_UP_RD;
        end else begin
          // move the child up into the hole
          h_we    = 1'b1;
          h_wd    = child;
          m_we    = 1'b1;
          m_wa    = child.own[IW-1:0];
          hole_d  = child_idx;
          moved_d = 1'b1;
          state_d = imht_pkg::S_DN_RD;
        end
      end
      imht_pkg::S_UP_RD: begin
        if (hole_q != '0) begin
          h_re_a  = 1'b1;
          h_ra    = parent;
          state_d = imht_pkg::S_UP_CMP;
        end else begin
          state_d = imht_pkg::S_PUT;
        end
      end
      imht_pkg::S_UP_CMP: begin
        if (imht_pkg::earlier(h_rda.dl, cur_q.dl, now_q)) begin
          state_d = imht_pkg::S_PUT;
        end else begin
          h_we    = 1'b1;
          h_wd    = h_rda;
          m_we    = 1'b1;
          m_wa    = h_rda.own[IW-1:0];
          hole_d  = parent;
          state_d = imht_pkg::S_UP_RD;
        end
      end
      imht_pkg::S_PUT: begin
        h_we    = 1'b1;
        m_we    = 1'b1;
        state_d = (op_q == imht_pkg::OP_TICK) ? imht_pkg::S_TOP : imht_pkg::S_WAIT;
      end
      imht_pkg::S_TOP: begin
        if ((size_q != '0) && (cnt_q < imht_pkg::RCW'(imht_pkg::MAX_RES))) begin
          h_re_a  = 1'b1;
          h_ra    = '0;
          state_d = imht_pkg::S_TCMP;
        end else begin
          state_d = imht_pkg::S_WAIT;
        end
      end
      imht_pkg::S_TCMP: begin
        if ((dtop != 32'd0) && !dtop[31]) begin
          state_d = imht_pkg::S_WAIT;
        end else begin
          // record the expired id and drop the root
          e_we    = 1'b1;
          cnt_d   = cnt_q + imht_pkg::RCW'(1);
          size_d  = size_m1;
          hole_d  = '0;
          if (size_m1 != '0) begin
            h_re_a  = 1'b1;
            h_ra    = size_m1[SW-1:0];
            state_d = imht_pkg::S_LAST;
          end else begin
            state_d = imht_pkg::S_TOP;
          end
        end
      end
      imht_pkg::S_WAIT: begin
        h_re_a  = 1'b1;
        h_ra    = '0;
        state_d = imht_pkg::S_WCALC;
      end
      imht_pkg::S_WCALC: begin
        wait_d  = imht_pkg::wait_of(h_rda.dl, now_q, size_q != '0);
        e_re    = 1'b1;
        e_ra    = '0;
        emit_d  = '0;
        state_d = imht_pkg::S_EMIT;
      end
      imht_pkg::S_EMIT: begin
        if ((op_q == imht_pkg::OP_TICK) && (cnt_q != '0)) begin
          res_o.kind = imht_pkg::KIND_EXP;
          res_o.id   = e_rd;
        end
        if (!res_full_i) begin
          res_push_o = 1'b1;
          emit_d     = emit_p1;
          e_re       = 1'b1;
          e_ra       = emit_p1[imht_pkg::EBW-1:0];
          if (res_o.last) state_d = imht_pkg::S_IDLE;
        end
      end
      default: state_d = imht_pkg::S_IDLE;
    endcase
  end

  assign busy_o = (state_q == imht_pkg::S_INIT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= imht_pkg::S_INIT;
      size_q  <= '0;
      now_q   <= '0;
      init_q  <= '0;
      cnt_q   <= '0;
      emit_q  <= '0;
      op_q    <= imht_pkg::OP_NOP;
      kind_q  <= imht_pkg::KIND_DONE;
      moved_q <= 1'b0;
      rv_q    <= 1'b0;
      inr_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      size_q  <= size_d;
      now_q   <= now_d;
      init_q  <= init_d;
      cnt_q   <= cnt_d;
      emit_q  <= emit_d;
      op_q    <= op_d;
      kind_q  <= kind_d;
      moved_q <= moved_d;
      rv_q    <= rv_d;
      inr_q   <= inr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q   <= id_d;
    tmo_q  <= tmo_d;
    s_q    <= s_d;
    hole_q <= hole_d;
    c_q    <= c_d;
    cur_q  <= cur_d;
    wait_q <= wait_d;
  end

endmodule

/* sv/indexed_min_heap_timer.sv */
// Indexed min-heap timer, top level: command front end, heap engine and
// result queue. Depends on imht_pkg, imht_front, imht_engine, imht_rfifo.
//
// Commands enter through push/full: a beat is taken at a clock edge with
// push high and full low. Results leave through empty/pop: the oldest result
// is on the result ports while empty is low and is taken with pop high.
// Every command gives at least one result; a tick gives one per expired id
// (up to 64), the final one flagged by last_o. All results of a command carry
// the wait to the next deadline after the whole command, or -1 if empty.
// A command waits in the command queue until the engine is idle. For an add,
// re-arm or delete the engine looks the id up in the map and sifts the heap
// up or down, comparing at each heap level; a tick drops each expired root
// in turn and sifts the last entry down from the root. Results are queued
// one per cycle while the result queue has room, and show in the next cycle
// at the earliest. A two-entry command queue takes commands while the engine
// works. After reset the id map is swept, one entry per cycle; full stays
// high during that pass. When the receiver stalls, results wait in a
// two-entry queue and the engine holds until there is room.
`include "indexed_min_heap_timer_assert.svh"
module indexed_min_heap_timer #(
  parameter int unsigned CAPACITY = 64,
  parameter int unsigned ID_COUNT = 65536
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic [2:0]         cmd_i,
  input  logic [15:0]        conn_id_i,
  input  logic [21:0]        timeout_ms_i,
  output logic               empty,
  input  logic               pop,
  output logic [1:0]         kind_o,
  output logic [15:0]        expired_id_o,
  output logic signed [22:0] next_wait_ms_o,
  output logic               last_o
);

  logic           busy, cmd_valid, cmd_pop, res_push, res_full;
  imht_pkg::cmd_t cmd;
  imht_pkg::res_t res_in, res_out;

  imht_front #(.ID_COUNT(ID_COUNT)) u_front (
    .clk_i, .rst_ni,
    .push_i(push), .full_o(full), .busy_i(busy),
    .cmd_i, .conn_id_i, .timeout_ms_i,
    .valid_o(cmd_valid), .pop_i(cmd_pop), .cmd_o(cmd)
  );

  imht_engine #(.CAPACITY(CAPACITY), .ID_COUNT(ID_COUNT)) u_engine (
    .clk_i, .rst_ni,
    .busy_o(busy),
    .cmd_valid_i(cmd_valid), .cmd_pop_o(cmd_pop), .cmd_i(cmd),
    .res_push_o(res_push), .res_full_i(res_full), .res_o(res_in)
  );

  imht_rfifo u_rfifo (
    .clk_i, .rst_ni,
    .push_i(res_push), .res_i(res_in), .full_o(res_full),
    .pop_i(pop), .empty_o(empty), .res_o(res_out)
  );

  assign kind_o         = res_out.kind;
  assign expired_id_o   = res_out.id;
  assign next_wait_ms_o = res_out.wait_ms;
  assign last_o         = res_out.last;

  `IMHT_ASSERT_IMP(a_pop_valid, cmd_pop, cmd_valid)
  `IMHT_ASSERT_IMP(a_push_room, res_push, !res_full)
  `IMHT_ASSERT_IMP(a_id_kind, !empty && (kind_o != imht_pkg::KIND_EXP), expired_id_o == 16'd0)
  `IMHT_ASSERT_IMP(a_busy_full, busy, full)
  `IMHT_ASSERT_NXT(a_res_hold, !empty && !pop, !empty)

endmodule
